// ----- src/barometric_pressure_compensation_macros.svh -----
// ----------------------------------------------------------------------------
// barometric pressure compensation assertion macros
// Shared assertion forms, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BPC_ASSERT_SAME(label, ante, cons)
`define BPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and helpers shared by the compensation block.
// ----------------------------------------------------------------------------
`default_nettype none
package bpc_pkg;

   // input item, raw pressure in the low bits
   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } item_type;

   // queue status toward the top level
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // trim register indexes
   localparam logic [1:0] REG_TEMP_TRIM   = 2'd0;
   localparam logic [1:0] REG_PRESS_FIRST = 2'd1;
   localparam logic [1:0] REG_PRESS_MID   = 2'd2;
   localparam logic [1:0] REG_PRESS_LAST  = 2'd3;

   localparam logic [63:0] TEMP_OFFSET = 64'd128000;
   localparam logic [63:0] PRESS_BASE  = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE = 64'd3125;
   localparam logic [63:0] TEMP_ROUND  = 64'd128;

   // sign extension of one trim word
   function automatic logic [63:0] sx16(input logic [15:0] w);
      return {{48{w[15]}}, w};
   endfunction

   // arithmetic right shift, floors
   function automatic logic [63:0] sar64(input logic [63:0] x, input int unsigned n);
      return 64'($signed(x) >>> n);
   endfunction

endpackage
`default_nettype wire

// ----- src/barometric_pressure_compensation.sv -----
// Each item runs thirteen 64-bit multiplies on one shared 32x32 multiplier and
// a radix-2 divider; a zero divisor ends the item after nine multiplies.
// The datapath takes one item at a time; a two-entry queue takes items ahead.
// Reset: synchronous, active high; clears trims to zero, queue and control state.
`default_nettype none
`include "barometric_pressure_compensation_macros.svh"
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
   // result items
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // temp_centi[31:0], press_q8[63:32]
   output      logic [0:0]  rsp_tuser,   // press_valid[0]
   // trim register writes
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_data
);

   logic [47:0] temp_trim_ff, press_first_ff, press_mid_ff, press_last_ff;
   logic        q_valid, q_ready;
   item_type    q_item, in_item;
   q_stat_type  q_stat;

   assign csr_ready = 1'b1;
   assign in_item   = item_type'(req_tdata);

   // trim registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff   <= 48'd0;
         press_first_ff <= 48'd0;
         press_mid_ff   <= 48'd0;
         press_last_ff  <= 48'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TEMP_TRIM:   temp_trim_ff   <= csr_data;
            REG_PRESS_FIRST: press_first_ff <= csr_data;
            REG_PRESS_MID:   press_mid_ff   <= csr_data;
            REG_PRESS_LAST:  press_last_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   bpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (in_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item),
      .stat       (q_stat)
   );

   bpc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (q_valid),
      .item_ready        (q_ready),
      .item              (q_item),
      .temp_trim         (temp_trim_ff),
      .press_trim_first  (press_first_ff),
      .press_trim_middle (press_mid_ff),
      .press_trim_last   (press_last_ff),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser)
   );

   // checks
   `BPC_ASSERT_SAME(a_invalid_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata[63:32] == 32'd0)
   `BPC_ASSERT_SAME(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty))
   `BPC_ASSERT_SAME(a_full_stalls, q_stat.full, !req_tready)

endmodule
`default_nettype wire

// ----- src/bpc_front.sv -----
// ----------------------------------------------------------------------------
// bpc_front
// Two-entry item queue between the request port and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_front
   import bpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   output      logic       push_ready,
   input  wire item_type   push_item,
   output      logic       pop_valid,
   input  wire logic       pop_ready,
   output      item_type   pop_item,
   output      q_stat_type stat
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ----- src/bpc_mul.sv -----
// ----------------------------------------------------------------------------
// bpc_mul
// 64 by 64 multiply, low 64 bits, from three 32 by 32 products.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_mul
   import bpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output      logic        done,
   output      logic [63:0] product
);

   logic [63:0] a_ff, b_ff;
   logic [63:0] prod_ff, acc_ff;
   logic [31:0] cross_ff;
   logic [1:0]  phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mx, my;

   assign done    = done_ff;
   assign product = acc_ff;

   // operand halves for this phase
   always_comb begin
      unique case (phase_ff)
         2'd0: begin mx = a_ff[31:0];  my = b_ff[31:0];  end
         2'd1: begin mx = a_ff[31:0];  my = b_ff[63:32]; end
         2'd2: begin mx = a_ff[63:32]; my = b_ff[31:0];  end
         default: begin mx = 32'd0;    my = 32'd0;       end
      endcase
   end

   // control
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 2'd0;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // products and accumulation
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      prod_ff <= {32'd0, mx} * {32'd0, my};
      if (busy_ff) begin
         unique case (phase_ff)
            2'd1: acc_ff <= prod_ff;
            2'd2: cross_ff <= prod_ff[31:0];
            2'd3: acc_ff <= acc_ff + {cross_ff + prod_ff[31:0], 32'd0};
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- src/bpc_div.sv -----
// ----------------------------------------------------------------------------
// bpc_div
// Signed 64-bit division truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_div
   import bpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output      logic        done,
   output      logic [63:0] quot
);

   logic [63:0] rem_ff, q_ff, d_ff;
   logic        neg_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] shifted, diff;

   assign done    = done_ff;
   assign quot    = neg_ff ? (64'd0 - q_ff) : q_ff;
   assign shifted = {rem_ff, q_ff[63]};
   assign diff    = shifted - {1'b0, d_ff};

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // restoring step on magnitudes
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[63] ^ den[63];
         rem_ff <= 64'd0;
         q_ff   <= num[63] ? (64'd0 - num) : num;
         d_ff   <= den[63] ? (64'd0 - den) : den;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            rem_ff <= diff[63:0];
            q_ff   <= {q_ff[62:0], 1'b1};
         end else begin
            rem_ff <= shifted[63:0];
            q_ff   <= {q_ff[62:0], 1'b0};
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/bpc_back.sv -----
// ----------------------------------------------------------------------------
// bpc_back
// Compensation sequencer over the shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_back
   import bpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   output      logic        item_ready,
   input  wire item_type    item,
   input  wire logic [47:0] temp_trim,
   input  wire logic [47:0] press_trim_first,
   input  wire logic [47:0] press_trim_middle,
   input  wire logic [47:0] press_trim_last,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,
   output      logic [0:0]  rsp_tuser
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_DIV  = 5'b00100,
      S_FIN  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   // sequencer steps
   localparam logic [3:0] ST_TA   = 4'd0;
   localparam logic [3:0] ST_DD   = 4'd1;
   localparam logic [3:0] ST_FINE = 4'd2;
   localparam logic [3:0] ST_AA   = 4'd3;
   localparam logic [3:0] ST_B6   = 4'd4;
   localparam logic [3:0] ST_B5   = 4'd5;
   localparam logic [3:0] ST_C3   = 4'd6;
   localparam logic [3:0] ST_C2   = 4'd7;
   localparam logic [3:0] ST_DV   = 4'd8;
   localparam logic [3:0] ST_NUM  = 4'd9;
   localparam logic [3:0] ST_Q9   = 4'd10;
   localparam logic [3:0] ST_QQ   = 4'd11;
   localparam logic [3:0] ST_P8   = 4'd12;

   state_type   state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic        mul_go_ff, mul_go_in;
   logic        div_go_ff, div_go_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        pvalid_ff;
   logic [19:0] adc_p_ff, adc_t_ff;
   logic [63:0] ta_ff, tb_ff, tmp_ff, fine_ff, aa_ff, b_ff, c_ff, dv_ff;
   logic [63:0] num_ff, p_ff, pf_ff;
   logic [63:0] rsp_data_ff;
   logic        rsp_user_ff;

   logic [63:0] mop_a, mop_b, mprod, quot;
   logic        mul_done, div_done;
   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [63:0] pa, pp, q, temp_full;
   logic [31:0] press_clamped;
   logic        out_free;

   // trim words
   assign t1 = {48'd0, temp_trim[15:0]};
   assign t2 = sx16(temp_trim[31:16]);
   assign t3 = sx16(temp_trim[47:32]);
   assign p1 = {48'd0, press_trim_first[15:0]};
   assign p2 = sx16(press_trim_first[31:16]);
   assign p3 = sx16(press_trim_first[47:32]);
   assign p4 = sx16(press_trim_middle[15:0]);
   assign p5 = sx16(press_trim_middle[31:16]);
   assign p6 = sx16(press_trim_middle[47:32]);
   assign p7 = sx16(press_trim_last[15:0]);
   assign p8 = sx16(press_trim_last[31:16]);
   assign p9 = sx16(press_trim_last[47:32]);

   assign pa = fine_ff - TEMP_OFFSET;
   assign pp = PRESS_BASE - {44'd0, adc_p_ff};
   assign q  = sar64(p_ff, 13);

   // multiplier operands per step
   always_comb begin
      unique case (step_ff)
         ST_TA: begin
            mop_a = {47'd0, adc_t_ff[19:3]} - {47'd0, t1[15:0], 1'b0};
            mop_b = t2;
         end
         ST_DD: begin
            mop_a = {48'd0, adc_t_ff[19:4]} - t1;
            mop_b = {48'd0, adc_t_ff[19:4]} - t1;
         end
         ST_FINE: begin mop_a = tmp_ff; mop_b = t3; end
         ST_AA:   begin mop_a = pa;     mop_b = pa; end
         ST_B6:   begin mop_a = aa_ff;  mop_b = p6; end
         ST_B5:   begin mop_a = pa;     mop_b = p5; end
         ST_C3:   begin mop_a = aa_ff;  mop_b = p3; end
         ST_C2:   begin mop_a = pa;     mop_b = p2; end
         ST_DV:   begin mop_a = (64'd1 << 47) + c_ff; mop_b = p1; end
         ST_NUM:  begin mop_a = {pp[32:0], 31'd0} - b_ff; mop_b = PRESS_SCALE; end
         ST_Q9:   begin mop_a = p9;     mop_b = q; end
         ST_QQ:   begin mop_a = tmp_ff; mop_b = q; end
         ST_P8:   begin mop_a = p8;     mop_b = p_ff; end
         default: begin mop_a = 64'd0;  mop_b = 64'd0; end
      endcase
   end

   bpc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_go_ff),
      .op_a    (mop_a),
      .op_b    (mop_b),
      .done    (mul_done),
      .product (mprod)
   );

   bpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (num_ff),
      .den   (dv_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign item_ready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // result formatting
   assign temp_full = sar64((fine_ff << 2) + fine_ff + TEMP_ROUND, 8);
   always_comb begin
      priority if (pf_ff[63]) begin
         press_clamped = 32'd0;
      end else if (|pf_ff[62:32]) begin
         press_clamped = 32'hFFFF_FFFF;
      end else begin
         press_clamped = pf_ff[31:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mul_go_in    = 1'b0;
      div_go_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               state_in  = S_MUL;
               step_in   = ST_TA;
               mul_go_in = 1'b1;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               priority if (step_ff == ST_DV && !(|mprod[63:33])) begin
                  state_in = S_OUT;
               end else if (step_ff == ST_NUM) begin
                  state_in  = S_DIV;
                  div_go_in = 1'b1;
               end else if (step_ff == ST_P8) begin
                  state_in = S_FIN;
               end else begin
                  step_in   = step_ff + 4'd1;
                  mul_go_in = 1'b1;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in  = S_MUL;
               step_in   = ST_Q9;
               mul_go_in = 1'b1;
            end
         end
         S_FIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_TA;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && item_valid) begin
         adc_p_ff <= item.raw_pressure;
         adc_t_ff <= item.raw_temperature;
      end
      if (state_ff == S_MUL && mul_done) begin
         unique case (step_ff)
            ST_TA:   ta_ff   <= sar64(mprod, 11);
            ST_DD:   tmp_ff  <= sar64(mprod, 12);
            ST_FINE: fine_ff <= ta_ff + sar64(mprod, 14);
            ST_AA:   aa_ff   <= mprod;
            ST_B6:   b_ff    <= mprod;
            ST_B5:   b_ff    <= b_ff + (mprod << 17) + (p4 << 35);
            ST_C3:   c_ff    <= sar64(mprod, 8);
            ST_C2:   c_ff    <= c_ff + (mprod << 12);
            ST_DV: begin
               dv_ff     <= sar64(mprod, 33);
               pvalid_ff <= |mprod[63:33];
            end
            ST_NUM:  num_ff  <= mprod;
            ST_Q9:   tmp_ff  <= mprod;
            ST_QQ:   ta_ff   <= sar64(mprod, 25);
            ST_P8:   tb_ff   <= sar64(mprod, 19);
            default: ;
         endcase
      end
      if (state_ff == S_DIV && div_done) begin
         p_ff <= quot;
      end
      if (state_ff == S_FIN) begin
         pf_ff <= sar64(p_ff + ta_ff + tb_ff, 8) + (p7 << 4);
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= {pvalid_ff ? press_clamped : 32'd0, temp_full[31:0]};
         rsp_user_ff <= pvalid_ff;
      end
   end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// barometric pressure compensation testbench
// Drives raw pressure and temperature readings through the block under
// several trim settings, predicts each result in 64-bit arithmetic and checks
// every result field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench
   import bpc_pkg::*;
();

   localparam int IDLE_LIMIT = 20000;
   localparam int PHASES = 6;
   localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

   typedef struct {
      logic [31:0] temp_centi;
      logic [31:0] press_q8;
      logic        press_valid;
   } reading_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [47:0] csr_data;

   // trim copy held by the predictor
   logic [47:0] trim_regs [4];

   item_type    pending_items [$];
   reading_type expected_readings [$];
   int          error_count;
   int          idle_cycles;
   int          checked_count;
   int          invalid_count;
   int          clamp_count;
   bit          stimulus_done;
   int          req_gap;
   int          rsp_gap;

   // accept seen at the last rising edge
   logic req_tready_seen;

   barometric_pressure_compensation u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] shr_a(input logic [63:0] x, input int n);
      return 64'($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] word_s(input logic [47:0] r, input int k);
      logic [15:0] w;
      w = r[16*k +: 16];
      return {{48{w[15]}}, w};
   endfunction

   function automatic logic [63:0] abs64(input logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   // compensated temperature and pressure for one reading pair
   function automatic reading_type compensate(input item_type it);
      logic [63:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, d, fine, p, q;
      reading_type r;
      adc_p = 64'(it.raw_pressure);
      adc_t = 64'(it.raw_temperature);
      t1 = 64'(trim_regs[REG_TEMP_TRIM][15:0]);
      t2 = word_s(trim_regs[REG_TEMP_TRIM], 1);
      t3 = word_s(trim_regs[REG_TEMP_TRIM], 2);
      p1 = 64'(trim_regs[REG_PRESS_FIRST][15:0]);
      p2 = word_s(trim_regs[REG_PRESS_FIRST], 1);
      p3 = word_s(trim_regs[REG_PRESS_FIRST], 2);
      p4 = word_s(trim_regs[REG_PRESS_MID], 0);
      p5 = word_s(trim_regs[REG_PRESS_MID], 1);
      p6 = word_s(trim_regs[REG_PRESS_MID], 2);
      p7 = word_s(trim_regs[REG_PRESS_LAST], 0);
      p8 = word_s(trim_regs[REG_PRESS_LAST], 1);
      p9 = word_s(trim_regs[REG_PRESS_LAST], 2);
      // temperature path
      a = shr_a(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      d = (adc_t >> 4) - t1;
      b = shr_a(shr_a(d * d, 12) * t3, 14);
      fine = a + b;
      r.temp_centi = 32'(shr_a(fine * 64'd5 + 64'd128, 8));
      // pressure path, wraps modulo 2^64
      a = fine - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = shr_a(a * a * p3, 8) + ((a * p2) << 12);
      a = shr_a(((64'd1 << 47) + a) * p1, 33);
      if (a == 64'd0) begin
         r.press_q8 = '0;
         r.press_valid = 1'b0;
         return r;
      end
      p = 64'd1048576 - adc_p;
      p = ((p << 31) - b) * 64'd3125;
      // truncating signed divide, most negative by -1 wraps
      q = abs64(p) / abs64(a);
      if (p[63] != a[63]) q = -q;
      p = q;
      q = shr_a(p, 13);
      a = shr_a(p9 * q * q, 25);
      b = shr_a(p8 * p, 19);
      p = shr_a(p + a + b, 8) + (p7 << 4);
      if (p[63]) p = 64'd0;
      else if (p > MASK32) p = MASK32;
      r.press_q8 = p[31:0];
      r.press_valid = 1'b1;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver: one item in flight on the request channel
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_tready_seen) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_items.pop_front();
            req_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_tready_seen <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_readings.push_back(compensate(item_type'(req_tdata)));
   end

   // result backpressure, mostly short stalls and a few long ones
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         rsp_gap = pick_gap();
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            exp_r = expected_readings.pop_front();
            checked_count++;
            if (!exp_r.press_valid) invalid_count++;
            if (exp_r.press_q8 == 32'hFFFF_FFFF) clamp_count++;
            if (rsp_tdata[31:0] !== exp_r.temp_centi) begin
               $error("temp_centi expected %0d got %0d",
                      $signed(exp_r.temp_centi), $signed(rsp_tdata[31:0]));
               error_count++;
            end
            if (rsp_tdata[63:32] !== exp_r.press_q8) begin
               $error("press_q8 expected %0d got %0d", exp_r.press_q8, rsp_tdata[63:32]);
               error_count++;
            end
            if (rsp_tuser[0] !== exp_r.press_valid) begin
               $error("press_valid expected %0d got %0d", exp_r.press_valid, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_trim(input logic [1:0] index, input logic [47:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      trim_regs[index] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_tvalid || expected_readings.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [19:0] rand_raw();
      case ($urandom_range(0, 5))
         0: return 20'h00000;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_word(input int phase);
      if (phase == 1) return 16'h8000;
      if (phase == 2) return 16'h7FFF;
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      return 16'($urandom);
   endfunction

   // stimulus
   initial begin
      item_type it;
      logic [47:0] value;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_TEMP_TRIM;
      csr_data = '0;
      req_tready_seen = 1'b0;
      error_count = 0;
      checked_count = 0;
      invalid_count = 0;
      clamp_count = 0;
      idle_cycles = 0;
      for (int i = 0; i < 4; i++) trim_regs[i] = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // trims at reset: zero divisor on every item
      it.raw_pressure = 20'h00000; it.raw_temperature = 20'hFFFFF;
      pending_items.push_back(it);
      it.raw_pressure = 20'hFFFFF; it.raw_temperature = 20'h00000;
      pending_items.push_back(it);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         // phase 0 typical sensor trims, 1 and 2 extremes, later random
         for (int r = 0; r < 4; r++) begin
            if (phase == 0) begin
               case (r)
                  0: value = {16'd50, 16'd26435, 16'd27504};
                  1: value = {16'd8838, -16'sd10685, 16'd36477};
                  2: value = {-16'sd1000, 16'd140, 16'd2855};
                  default: value = {16'd6000, -16'sd14600, 16'd15500};
               endcase
            end else if (phase == 3 && r == REG_PRESS_FIRST) begin
               value = {rand_word(3), rand_word(3), 16'h0000};
            end else begin
               value = {rand_word(phase), rand_word(phase), rand_word(phase)};
               if (phase == 2 && r != REG_PRESS_LAST) value[15:0] = 16'hFFFF;
            end
            write_trim(2'(r), value);
         end
         // directed edges of the raw fields
         for (int k = 0; k < 4; k++) begin
            it.raw_pressure = k[0] ? 20'hFFFFF : 20'h00000;
            it.raw_temperature = k[1] ? 20'hFFFFF : 20'h00000;
            pending_items.push_back(it);
         end
         for (int k = 0; k < 170; k++) begin
            it.raw_pressure = rand_raw();
            it.raw_temperature = rand_raw();
            pending_items.push_back(it);
         end
         wait_drained();
      end

      $display("checked %0d results over %0d trim settings", checked_count, PHASES + 1);
      $display("zero divisor results %0d, clamped high results %0d",
               invalid_count, clamp_count);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
